[rtl/wrts_pkg.sv]
// Shared types and constants of the weekly relay task scheduler.
// No dependencies; imported by every module of the block.
package wrts_pkg;

    localparam logic [6:0] ONESHOT_MASK = 7'h00;

    localparam logic REG_REPORT_INTERVAL = 1'b0;
    localparam logic [7:0] REPORT_INTERVAL_RST = 8'd1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic       time_valid;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [1:0] plug_index;
        logic [1:0] task_index;
        logic       task_enable;
        logic [6:0] task_repeat;
        logic       task_action;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0] plug_states;
        logic       settings_changed;
        logic [3:0] oneshot_fired;
        logic [7:0] oneshot_slot;
        logic       report_due;
    } res_beat_t;

    typedef struct packed {
        logic       enable;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] repeat_mask;
        logic       action;
    } task_entry_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

[rtl/wrts_task_mem.sv]
// Task entry memory: one write port, one registered read port.
// Per-entry valid flops make unwritten entries read as disabled. Uses wrts_pkg.
module wrts_task_mem #(
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wrts_pkg::mem_ctrl_t   ctrl,
    input  logic [AW-1:0]         waddr,
    input  wrts_pkg::task_entry_t wdata,
    input  logic [AW-1:0]         raddr,
    output wrts_pkg::task_entry_t rdata
);
    import wrts_pkg::*;

    task_entry_t          entry_mem [DEPTH];
    task_entry_t          rdata_reg;
    logic                 rvalid_reg;
    logic [DEPTH-1:0]     valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctrl.re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

[rtl/wrts_scan.sv]
// Command sequencer: task writes, table scan on ticks, plug state, report counter,
// result register. Drives the task memory. Uses wrts_pkg.
module wrts_scan #(
    parameter int PLUGS = 4,
    parameter int TASKS_PER_PLUG = 4,
    parameter int AW = (PLUGS * TASKS_PER_PLUG > 1) ? $clog2(PLUGS * TASKS_PER_PLUG) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  wrts_pkg::cmd_beat_t   cmd_beat,
    output logic                  res_valid,
    input  logic                  res_stall,
    output wrts_pkg::res_beat_t   res_beat,
    input  logic [7:0]            report_interval,
    output wrts_pkg::mem_ctrl_t   mem_ctrl,
    output logic [AW-1:0]         mem_waddr,
    output wrts_pkg::task_entry_t mem_wdata,
    output logic [AW-1:0]         mem_raddr,
    input  wrts_pkg::task_entry_t mem_rdata
);
    import wrts_pkg::*;

    localparam int DEPTH = PLUGS * TASKS_PER_PLUG;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (PLUGS > 1) ? $clog2(PLUGS) : 1;
    localparam int TW = (TASKS_PER_PLUG > 1) ? $clog2(TASKS_PER_PLUG) : 1;

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    iss_reg, iss_next;
    logic             ev_vld_reg, ev_vld_next;
    logic [AW-1:0]    ev_addr_reg, ev_addr_next;
    logic [PW-1:0]    ev_plug_reg, ev_plug_next;
    logic [TW-1:0]    ev_task_reg, ev_task_next;
    logic [5:0]       minute_reg, minute_next;
    logic [4:0]       hour_reg, hour_next;
    logic [6:0]       day_reg, day_next;
    logic [PLUGS-1:0] plug_reg, plug_next;
    logic             changed_reg, changed_next;
    logic [3:0]       fired_reg, fired_next;
    logic [7:0]       slots_reg, slots_next;
    logic             due_reg, due_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    res_beat_t        res_beat_reg, res_beat_next;

    logic             accept;
    logic             res_take;
    logic [7:0]       cnt_inc;
    logic             cnt_hit;
    logic [6:0]       daybit;
    logic [PLUGS+3:0] plug_ext;
    logic             wr_in_range;
    logic [AW-1:0]    wr_addr;
    logic             hit;
    logic             oneshot;
    logic [PLUGS-1:0] plug_upd;
    task_entry_t      wb_entry;

    assign res_take  = res_valid_reg && !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

    assign cnt_inc = cnt_reg + 8'd1;
    assign cnt_hit = (cnt_inc >= report_interval);
    assign daybit  = (cmd_beat.weekday == 3'd0) ? 7'd0
                   : (7'd1 << (cmd_beat.weekday - 3'd1));
    assign plug_ext = {4'b0, plug_reg};

    assign wr_in_range = (int'(cmd_beat.plug_index) < PLUGS)
                      && (int'(cmd_beat.task_index) < TASKS_PER_PLUG);
    assign wr_addr = AW'(int'(cmd_beat.plug_index) * TASKS_PER_PLUG
                       + int'(cmd_beat.task_index));

    assign oneshot = (mem_rdata.repeat_mask == ONESHOT_MASK);
    assign hit = mem_rdata.enable
              && (mem_rdata.minute == minute_reg)
              && (mem_rdata.hour == hour_reg)
              && (oneshot || ((mem_rdata.repeat_mask & day_reg) != 7'd0));

    always_comb
    begin
        wb_entry        = mem_rdata;
        wb_entry.enable = 1'b0;
    end

    always_comb
    begin
        plug_upd = plug_reg;
        for (int i = 0; i < PLUGS; i++)
        begin
            if (int'(ev_plug_reg) == i)
            begin
                plug_upd[i] = mem_rdata.action;
            end
        end
        if ((ev_plug_reg != '0) && mem_rdata.action)
        begin
            plug_upd[0] = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        ev_vld_next    = ev_vld_reg;
        ev_addr_next   = ev_addr_reg;
        ev_plug_next   = ev_plug_reg;
        ev_task_next   = ev_task_reg;
        minute_next    = minute_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        plug_next      = plug_reg;
        changed_next   = changed_reg;
        fired_next     = fired_reg;
        slots_next     = slots_reg;
        due_next       = due_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_take ? 1'b0 : res_valid_reg;
        res_beat_next  = res_beat_reg;
        mem_ctrl       = '0;
        mem_waddr      = ev_addr_reg;
        mem_wdata      = wb_entry;
        mem_raddr      = iss_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_beat.cmd == CMD_WRITE)
                    begin
                        if (wr_in_range)
                        begin
                            mem_ctrl.we = 1'b1;
                            mem_waddr   = wr_addr;
                            mem_wdata   = '{enable:      cmd_beat.task_enable,
                                            hour:        cmd_beat.hour,
                                            minute:      cmd_beat.minute,
                                            repeat_mask: cmd_beat.task_repeat,
                                            action:      cmd_beat.task_action};
                        end
                        res_valid_next = 1'b1;
                        res_beat_next  = '0;
                        res_beat_next.plug_states = plug_ext[3:0];
                    end
                    else
                    begin
                        cnt_next = cnt_hit ? 8'd0 : cnt_inc;
                        if (cmd_beat.time_valid && (cmd_beat.second == 6'd0))
                        begin
                            state_next   = ST_SCAN;
                            iss_next     = '0;
                            ev_vld_next  = 1'b0;
                            ev_plug_next = '0;
                            ev_task_next = '0;
                            minute_next  = cmd_beat.minute;
                            hour_next    = cmd_beat.hour;
                            day_next     = daybit;
                            changed_next = 1'b0;
                            fired_next   = '0;
                            slots_next   = '0;
                            due_next     = cnt_hit;
                        end
                        else
                        begin
                            res_valid_next = 1'b1;
                            res_beat_next  = '0;
                            res_beat_next.plug_states = plug_ext[3:0];
                            res_beat_next.report_due  = cnt_hit;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (iss_reg != CW'(DEPTH))
                begin
                    mem_ctrl.re  = 1'b1;
                    iss_next     = iss_reg + CW'(1);
                    ev_vld_next  = 1'b1;
                    ev_addr_next = iss_reg[AW-1:0];
                end
                else
                begin
                    ev_vld_next = 1'b0;
                end

                if (ev_vld_reg)
                begin
                    if (hit)
                    begin
                        plug_next    = plug_upd;
                        changed_next = changed_reg || (plug_upd != plug_reg) || oneshot;
                        if (oneshot)
                        begin
                            mem_ctrl.we = 1'b1;
                            for (int i = 0; i < 4; i++)
                            begin
                                if (int'(ev_plug_reg) == i)
                                begin
                                    fired_next[i]        = 1'b1;
                                    slots_next[2*i +: 2] = 2'(ev_task_reg);
                                end
                            end
                        end
                    end
                    if (ev_task_reg == TW'(TASKS_PER_PLUG - 1))
                    begin
                        ev_task_next = '0;
                        ev_plug_next = ev_plug_reg + PW'(1);
                    end
                    else
                    begin
                        ev_task_next = ev_task_reg + TW'(1);
                    end
                end

                if ((iss_reg == CW'(DEPTH)) && !ev_vld_reg)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    res_beat_next.plug_states      = plug_ext[3:0];
                    res_beat_next.settings_changed = changed_reg;
                    res_beat_next.oneshot_fired    = fired_reg;
                    res_beat_next.oneshot_slot     = slots_reg;
                    res_beat_next.report_due       = due_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= '0;
            ev_vld_reg    <= 1'b0;
            ev_addr_reg   <= '0;
            ev_plug_reg   <= '0;
            ev_task_reg   <= '0;
            minute_reg    <= '0;
            hour_reg      <= '0;
            day_reg       <= '0;
            plug_reg      <= '0;
            changed_reg   <= 1'b0;
            fired_reg     <= '0;
            slots_reg     <= '0;
            due_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_beat_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            ev_vld_reg    <= ev_vld_next;
            ev_addr_reg   <= ev_addr_next;
            ev_plug_reg   <= ev_plug_next;
            ev_task_reg   <= ev_task_next;
            minute_reg    <= minute_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            plug_reg      <= plug_next;
            changed_reg   <= changed_next;
            fired_reg     <= fired_next;
            slots_reg     <= slots_next;
            due_reg       <= due_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            res_beat_reg  <= res_beat_next;
        end
    end

`ifndef ASSERT_OFF
    a_wb_not_read_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctrl.we && mem_ctrl.re) |-> (mem_waddr != mem_raddr))
        else $error("write-back collides with scan read");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> (state_reg == ST_SCAN))
        else $error("entry evaluated outside scan");

    a_scan_write_is_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctrl.we && (state_reg == ST_SCAN)) |-> ev_vld_reg)
        else $error("scan write without evaluated entry");

    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg <= CW'(DEPTH))
        else $error("scan issue counter overran table");

    a_oneshot_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_beat_reg.oneshot_fired != 4'd0))
        |-> res_beat_reg.settings_changed)
        else $error("one-shot fired without settings change");
`endif

endmodule

[rtl/weekly_relay_task_scheduler.sv]
// Results: a write or a tick without a scan gives its result in the cycle after the beat
// is taken; a tick with valid time at second 0 gives it when its ST_SCAN pass ends.
// Beats: one beat per cycle without a scan, while the result channel does not stall; no
// beat is taken during a scan, which reads the single read port of the task memory (one entry per cycle).
// Reset: all tasks disabled, plugs off, counter zero, report_interval 1; no clearing pass.
// Top level: APB register, task memory (wrts_task_mem), sequencer (wrts_scan). Uses wrts_pkg.
module weekly_relay_task_scheduler #(
    parameter int PLUGS = 4,
    parameter int TASKS_PER_PLUG = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  wrts_pkg::cmd_beat_t cmd_beat,
    output logic                res_valid,
    input  logic                res_stall,
    output wrts_pkg::res_beat_t res_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wrts_pkg::*;

    localparam int DEPTH = PLUGS * TASKS_PER_PLUG;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    report_interval_reg;
    mem_ctrl_t     mem_ctrl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    task_entry_t   mem_wdata;
    task_entry_t   mem_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPORT_INTERVAL) ? 32'(report_interval_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_interval_reg <= REPORT_INTERVAL_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_REPORT_INTERVAL))
        begin
            report_interval_reg <= pwdata[7:0];
        end
    end

    wrts_task_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wrts_scan #(
        .PLUGS          (PLUGS),
        .TASKS_PER_PLUG (TASKS_PER_PLUG),
        .AW             (AW)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd_beat        (cmd_beat),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_beat        (res_beat),
        .report_interval (report_interval_reg),
        .mem_ctrl        (mem_ctrl),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

endmodule

[sim/tb_weekly_relay_task_scheduler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for weekly_relay_task_scheduler: directed and random
// command beats, randomized idling on both channels, APB interval settings.
// Depends on rtl/wrts_pkg.sv and rtl/weekly_relay_task_scheduler.sv.
module tb_weekly_relay_task_scheduler;
    import wrts_pkg::*;

    localparam int PLUGS = 4;
    localparam int TASKS = 4;
    localparam int SCAN_LAT = PLUGS * TASKS + 2;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_ITEMS = 90;

    class relay_scoreboard;
        task_entry_t entries[PLUGS * TASKS];
        logic [3:0]  plugs;
        logic [7:0]  tick_count;
        logic [7:0]  interval;
        res_beat_t   due_results[$];
        int errors, n_writes, n_ticks, n_results, n_changed, n_oneshots, n_reports;

        function new();
            foreach (entries[i]) entries[i] = '0;
            plugs = '0;
            tick_count = '0;
            interval = REPORT_INTERVAL_RST;
        endfunction

        function void set_interval(logic [7:0] value);
            interval = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function res_beat_t predict_outcome(cmd_beat_t b);
            res_beat_t   r;
            logic [6:0]  day_bit;
            task_entry_t e;
            int          idx;
            r = '0;
            if (b.cmd == CMD_WRITE) begin
                idx = int'(b.plug_index) * TASKS + int'(b.task_index);
                entries[idx].enable = b.task_enable;
                entries[idx].hour = b.hour;
                entries[idx].minute = b.minute;
                entries[idx].repeat_mask = b.task_repeat;
                entries[idx].action = b.task_action;
            end else begin
                day_bit = (b.weekday >= 3'd1) ? (7'd1 << (b.weekday - 3'd1)) : 7'd0;
                if (b.time_valid && b.second == 6'd0) begin
                    for (int p = 0; p < PLUGS; p++) begin
                        for (int t = 0; t < TASKS; t++) begin
                            idx = p * TASKS + t;
                            e = entries[idx];
                            if (!e.enable || e.minute != b.minute || e.hour != b.hour)
                                continue;
                            if (e.repeat_mask != ONESHOT_MASK && (e.repeat_mask & day_bit) == 7'd0)
                                continue;
                            if (plugs[p] != e.action) begin
                                plugs[p] = e.action;
                                r.settings_changed = 1'b1;
                            end
                            if (e.repeat_mask == ONESHOT_MASK) begin
                                entries[idx].enable = 1'b0;
                                r.settings_changed = 1'b1;
                                r.oneshot_fired[p] = 1'b1;
                                r.oneshot_slot[2*p +: 2] = 2'(t);
                            end
                            if (p > 0 && plugs[p] && !plugs[0]) begin
                                plugs[0] = 1'b1;
                                r.settings_changed = 1'b1;
                            end
                        end
                    end
                end
                tick_count = tick_count + 8'd1;
                if (tick_count >= interval) begin
                    tick_count = '0;
                    r.report_due = 1'b1;
                end
            end
            r.plug_states = plugs;
            return r;
        endfunction

        function void note_command(cmd_beat_t b);
            res_beat_t r;
            r = predict_outcome(b);
            if (b.cmd == CMD_WRITE) n_writes++;
            else n_ticks++;
            if (r.settings_changed) n_changed++;
            if (r.report_due) n_reports++;
            n_oneshots += $countones(r.oneshot_fired);
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_beat_t got);
            res_beat_t want;
            if (due_results.size() == 0) begin
                $error("result beat 0x%h with no expectation pending", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            n_results++;
            compare_field("plug_states", 8'(want.plug_states), 8'(got.plug_states));
            compare_field("settings_changed", 8'(want.settings_changed),
                          8'(got.settings_changed));
            compare_field("oneshot_fired", 8'(want.oneshot_fired), 8'(got.oneshot_fired));
            compare_field("oneshot_slot", want.oneshot_slot, got.oneshot_slot);
            compare_field("report_due", 8'(want.report_due), 8'(got.report_due));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_beat_t   cmd_beat;
    logic        res_valid;
    logic        res_stall;
    res_beat_t   res_beat;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    relay_scoreboard sb;
    int idle_max = 17;
    int stall_left = 0;
    int n_settings = 0;
    logic [4:0] pool_hour[4];
    logic [5:0] pool_minute[4];

    weekly_relay_task_scheduler #(
        .PLUGS(PLUGS),
        .TASKS_PER_PLUG(TASKS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_beat(cmd_beat),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_beat(res_beat),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd_beat);
            if (res_valid && !res_stall)
            begin
                sb.check_result(res_beat);
                stall_left = $urandom_range(idle_max, 0);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
            res_stall <= 1'b0;
    end

    function automatic cmd_beat_t rand_beat();
        cmd_beat_t b;
        b.cmd = 1'($urandom_range(1, 0));
        b.time_valid = 1'($urandom_range(1, 0));
        b.second = 6'($urandom_range(63, 0));
        b.minute = 6'($urandom_range(63, 0));
        b.hour = 5'($urandom_range(31, 0));
        b.weekday = 3'($urandom_range(7, 0));
        b.plug_index = 2'($urandom_range(3, 0));
        b.task_index = 2'($urandom_range(3, 0));
        b.task_enable = 1'($urandom_range(1, 0));
        b.task_repeat = 7'($urandom_range(127, 0));
        b.task_action = 1'($urandom_range(1, 0));
        return b;
    endfunction

    function automatic cmd_beat_t mk_write(int p, int t, bit en, int hr, int mn,
                                           int rep, bit act);
        cmd_beat_t b;
        b = rand_beat();
        b.cmd = CMD_WRITE;
        b.plug_index = 2'(p);
        b.task_index = 2'(t);
        b.task_enable = en;
        b.hour = 5'(hr);
        b.minute = 6'(mn);
        b.task_repeat = 7'(rep);
        b.task_action = act;
        return b;
    endfunction

    function automatic cmd_beat_t mk_tick(bit valid, int hr, int mn, int sec, int wd);
        cmd_beat_t b;
        b = rand_beat();
        b.cmd = CMD_TICK;
        b.time_valid = valid;
        b.hour = 5'(hr);
        b.minute = 6'(mn);
        b.second = 6'(sec);
        b.weekday = 3'(wd);
        return b;
    endfunction

    // mostly writes and second-zero ticks on a few shared times, plus noise
    function automatic cmd_beat_t random_command();
        cmd_beat_t b;
        int        r;
        int        k;
        b = rand_beat();
        r = $urandom_range(99, 0);
        k = $urandom_range(3, 0);
        if (r < 30)
        begin
            b.cmd = CMD_WRITE;
            if ($urandom_range(4, 0) != 0)
            begin
                b.hour = pool_hour[k];
                b.minute = pool_minute[k];
            end
            b.task_enable = ($urandom_range(3, 0) != 0);
            if ($urandom_range(9, 0) < 3)
                b.task_repeat = ONESHOT_MASK;
        end
        else if (r < 85)
        begin
            b.cmd = CMD_TICK;
            b.time_valid = 1'b1;
            if ($urandom_range(19, 0) < 17)
                b.second = '0;
            if ($urandom_range(19, 0) < 17)
            begin
                b.hour = pool_hour[k];
                b.minute = pool_minute[k];
            end
            if ($urandom_range(9, 0) != 0)
                b.weekday = 3'($urandom_range(7, 1));
        end
        return b;
    endfunction

    task automatic send_command(cmd_beat_t b);
        repeat ($urandom_range(idle_max, 0))
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_beat <= b;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending() > 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (sb.pending() > 0)
        begin
            $error("%0d result beats still outstanding", sb.pending());
            sb.errors++;
            sb.due_results.delete();
        end
        repeat (2 * SCAN_LAT) @(posedge clk);
    endtask

    task automatic set_report_interval(logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_REPORT_INTERVAL, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_interval(value);
        n_settings++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            $error("report_interval readback: expected 0x%08h, got 0x%08h",
                   {24'd0, value}, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] iv;
        cmd_valid = 1'b0;
        cmd_beat = '0;
        res_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, one-shot with plug 0 forced on, weekday masks,
        // weekday 0, no valid time, nonzero second, out-of-range time, disabled task
        send_command(mk_tick(1, 0, 0, 0, 1));
        send_command(mk_write(2, 3, 1, 23, 59, ONESHOT_MASK, 1));
        send_command(mk_tick(1, 23, 59, 0, 7));
        send_command(mk_tick(1, 23, 59, 0, 7));
        send_command(mk_write(1, 0, 1, 0, 0, 7'h40, 1));
        send_command(mk_tick(1, 0, 0, 0, 6));
        send_command(mk_tick(1, 0, 0, 0, 7));
        send_command(mk_write(0, 1, 1, 0, 0, ONESHOT_MASK, 0));
        send_command(mk_tick(1, 0, 0, 0, 0));
        send_command(mk_tick(0, 0, 0, 0, 7));
        send_command(mk_tick(1, 0, 0, 30, 7));
        send_command(mk_write(3, 0, 1, 12, 30, ONESHOT_MASK, 1));
        send_command(mk_write(3, 2, 1, 12, 30, ONESHOT_MASK, 0));
        send_command(mk_tick(1, 12, 30, 0, 3));
        send_command(mk_write(3, 3, 1, 31, 63, 7'h7f, 1));
        send_command(mk_tick(1, 31, 63, 0, 7));
        send_command(mk_write(0, 0, 0, 10, 10, 7'h7f, 1));
        send_command(mk_tick(1, 10, 10, 0, 4));
        send_command(mk_write(1, 0, 1, 0, 0, 7'h7f, 0));
        send_command(mk_tick(1, 0, 0, 0, 1));
        send_command(mk_tick(1, 31, 63, 63, 7));
        send_command(mk_tick(1, 0, 0, 0, 5));

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0: iv = 8'd0;
                1: iv = 8'd255;
                2: iv = 8'd3;
                3: iv = 8'($urandom_range(254, 4));
                default: iv = REPORT_INTERVAL_RST;
            endcase
            set_report_interval(iv);
            for (int k = 0; k < 4; k++)
            begin
                pool_hour[k] = 5'($urandom_range(23, 0));
                pool_minute[k] = 6'($urandom_range(59, 0));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(29, 0) == 0)
                    idle_max = (idle_max == 0) ? 17 : 0;
                if ($urandom_range(49, 0) == 0)
                    wait_idle();
                send_command(random_command());
            end
        end

        idle_max = 17;
        wait_idle();
        $display("%0d writes and %0d ticks sent over %0d interval settings; %0d results checked",
                 sb.n_writes, sb.n_ticks, n_settings, sb.n_results);
        $display("%0d ticks changed settings, %0d one-shot firings, %0d report requests",
                 sb.n_changed, sb.n_oneshots, sb.n_reports);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
